// ----- design/dpdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual PID differential drive package
// Widths, register indexes, reset values and speed bounds shared by the
// drive controller, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package dpdd_pkg;

  // Field widths of the transfers on the two channels.
  localparam int POS_W   = 13;
  localparam int ERR_W   = 14;
  localparam int SPEED_W = 11;

  // Configuration port.
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;

  // Integrator width.
  localparam int SUM_W = 32;

  typedef enum logic [2:0] {
    CFG_STEER_P  = 3'd0,
    CFG_STEER_D  = 3'd1,
    CFG_STEER_I  = 3'd2,
    CFG_SLOW_P   = 3'd3,
    CFG_SLOW_D   = 3'd4,
    CFG_SLOW_I   = 3'd5,
    CFG_CRUISE   = 3'd6,
    CFG_CENTER   = 3'd7
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]         RST_STEER_P = GAIN_W'(369);
  localparam logic [GAIN_W-1:0]         RST_STEER_D = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0]         RST_STEER_I = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]         RST_SLOW_P  = GAIN_W'(123);
  localparam logic [GAIN_W-1:0]         RST_SLOW_D  = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]         RST_SLOW_I  = GAIN_W'(0);
  localparam logic signed [SPEED_W-1:0] RST_CRUISE  = SPEED_W'(1000);
  localparam logic [POS_W-1:0]          RST_CENTER  = POS_W'(3000);

  // Motor speed bounds; the lower bound is applied last.
  localparam logic signed [SPEED_W-1:0] SPEED_UPPER = SPEED_W'(100);
  localparam logic signed [SPEED_W-1:0] SPEED_LOWER = -SPEED_W'(100);

endpackage

// ----- design/dpdd_in_if.sv -----
// ----------------------------------------------------------------------------
// Drive controller input channel
// Valid/ready channel that carries one filtered line position per transfer.
// ----------------------------------------------------------------------------
interface dpdd_in_if;
  import dpdd_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] line_position;

  modport source (output valid, output line_position, input ready);
  modport sink   (input valid, input line_position, output ready);
endinterface

// ----- design/dpdd_out_if.sv -----
// ----------------------------------------------------------------------------
// Drive controller result channel
// Valid/ready channel that carries both wheel speeds and the position error.
// ----------------------------------------------------------------------------
interface dpdd_out_if;
  import dpdd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] right_speed;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [ERR_W-1:0]   position_error;

  modport source (output valid, output right_speed, output left_speed,
                  output position_error, input ready);
  modport sink   (input valid, input right_speed, input left_speed,
                  input position_error, output ready);
endinterface

// ----- design/dual_pid_differential_drive.sv -----
// ----------------------------------------------------------------------------
// Dual PID differential drive controller
// Steering PID and slowdown PID on a line position, producing clamped left
// and right motor speeds in a four-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// How to use this block:
// Send one filtered line position per transfer on in_chan. For each one the
// block returns exactly one transfer on out_chan holding the right and left
// wheel speeds and the signed position error of that sample, in order.
// The pipeline has four registered stages: error and integrators, the six
// gain products, the two PID sums, and the speed/clamp output register.
// With out_chan.ready held high, one input transfer is taken every cycle.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling; in_chan.ready drops only once every stage
// holds an item, so up to four results can be in flight. Gains, cruise speed
// and line center are written through cfg_we, cfg_index and cfg_wdata, one
// register per cycle; the user must write them only while the pipeline is
// empty, as the block itself does not enforce it. A synchronous reset (rst_n
// low) empties the pipeline, clears the error history and both integrators,
// and loads the default gains and settings.
// ----------------------------------------------------------------------------
module dual_pid_differential_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  dpdd_in_if.sink                         in_chan,
  dpdd_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  dpdd_pkg::cfg_idx_t              cfg_index,
  input  logic [dpdd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dpdd_pkg::*;

  // Internal widths of the arithmetic.
  localparam int DERR_W = ERR_W + 1;   // difference of two signed errors
  localparam int DABS_W = ERR_W;       // difference of two magnitudes
  localparam int PP_W   = 31;          // gain times error or magnitude
  localparam int PD_W   = 32;          // gain times signed difference
  localparam int PI_W   = 49;          // gain times integrator
  localparam int ACC_W  = 50;          // sum of three products
  localparam int FRAC_W = 12;          // Q4.12 fraction bits
  localparam int Q_W    = ACC_W - FRAC_W;
  localparam int SPD_W  = Q_W + 2;     // cruise minus slowdown plus steering

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]         steer_p_r, steer_d_r, steer_i_r;
  logic [GAIN_W-1:0]         slow_p_r, slow_d_r, slow_i_r;
  logic signed [SPEED_W-1:0] cruise_r;
  logic [POS_W-1:0]          center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_p_r <= RST_STEER_P;
      steer_d_r <= RST_STEER_D;
      steer_i_r <= RST_STEER_I;
      slow_p_r  <= RST_SLOW_P;
      slow_d_r  <= RST_SLOW_D;
      slow_i_r  <= RST_SLOW_I;
      cruise_r  <= RST_CRUISE;
      center_r  <= RST_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEER_P: steer_p_r <= cfg_wdata;
        CFG_STEER_D: steer_d_r <= cfg_wdata;
        CFG_STEER_I: steer_i_r <= cfg_wdata;
        CFG_SLOW_P:  slow_p_r  <= cfg_wdata;
        CFG_SLOW_D:  slow_d_r  <= cfg_wdata;
        CFG_SLOW_I:  slow_i_r  <= cfg_wdata;
        CFG_CRUISE:  cruise_r  <= cfg_wdata[SPEED_W-1:0];
        CFG_CENTER:  center_r  <= cfg_wdata[POS_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage may load when it is empty or when the
  // stage after it is moving, so a stall at the output only backs up as far
  // as there are occupied stages.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv4;
  logic in_xfer;

  assign adv4    = !out_valid_r || out_chan.ready;
  assign adv3    = !v3_r || adv4;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;
  assign in_xfer = in_chan.valid && adv1;

  assign in_chan.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_chan.valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: error, derivatives and saturating integrators.
  // The controller history is updated on every input transfer. Because the
  // first stage loads only when it is empty or passes its item on, the
  // history registers always describe the item that stage 1 currently holds,
  // so they double as that stage's error, magnitude and integrator registers.
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  prev_error_r;
  logic [POS_W-1:0]         prev_abs_error_r;
  logic signed [SUM_W-1:0]  error_sum_r, abs_error_sum_r;
  logic signed [DERR_W-1:0] d_err_r;
  logic signed [DABS_W-1:0] d_abs_r;

  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [ERR_W-1:0]  neg_err;
  logic [POS_W-1:0]         abs_nxt;
  logic signed [DERR_W-1:0] d_err_nxt;
  logic signed [DABS_W-1:0] d_abs_nxt;
  logic signed [SUM_W:0]    esum_wide, asum_wide;
  logic signed [SUM_W-1:0]  error_sum_nxt, abs_error_sum_nxt;

  // Saturate a sum that is one bit wider than an integrator.
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
    logic signed [SUM_W-1:0] r;
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    err_nxt   = $signed({1'b0, in_chan.line_position}) - $signed({1'b0, center_r});
    neg_err   = -err_nxt;
    abs_nxt   = err_nxt[ERR_W-1] ? neg_err[POS_W-1:0] : err_nxt[POS_W-1:0];
    d_err_nxt = DERR_W'(err_nxt) - DERR_W'(prev_error_r);
    d_abs_nxt = $signed({1'b0, abs_nxt}) - $signed({1'b0, prev_abs_error_r});
    esum_wide = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(err_nxt);
    asum_wide = (SUM_W+1)'(abs_error_sum_r) + $signed({{(SUM_W+1-POS_W){1'b0}}, abs_nxt});
    error_sum_nxt     = sat_sum(esum_wide);
    abs_error_sum_nxt = sat_sum(asum_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r     <= '0;
      prev_abs_error_r <= '0;
      error_sum_r      <= '0;
      abs_error_sum_r  <= '0;
    end else if (in_xfer) begin
      prev_error_r     <= err_nxt;
      prev_abs_error_r <= abs_nxt;
      error_sum_r      <= error_sum_nxt;
      abs_error_sum_r  <= abs_error_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      d_err_r <= d_err_nxt;
      d_abs_r <= d_abs_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the six gain products, each gain taken as a positive signed
  // value so the products come out signed.
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0]  steer_pp_r, slow_pp_r, slow_pd_r;
  logic signed [PD_W-1:0]  steer_pd_r;
  logic signed [PI_W-1:0]  steer_pi_r, slow_pi_r;
  logic signed [ERR_W-1:0] err_b_r;

  logic signed [PP_W-1:0]  steer_pp_nxt, slow_pp_nxt, slow_pd_nxt;
  logic signed [PD_W-1:0]  steer_pd_nxt;
  logic signed [PI_W-1:0]  steer_pi_nxt, slow_pi_nxt;

  always_comb begin
    steer_pp_nxt = PP_W'($signed({1'b0, steer_p_r})) * PP_W'(prev_error_r);
    steer_pd_nxt = PD_W'($signed({1'b0, steer_d_r})) * PD_W'(d_err_r);
    steer_pi_nxt = PI_W'($signed({1'b0, steer_i_r})) * PI_W'(error_sum_r);
    slow_pp_nxt  = PP_W'($signed({1'b0, slow_p_r}))
                   * PP_W'($signed({1'b0, prev_abs_error_r}));
    slow_pd_nxt  = PP_W'($signed({1'b0, slow_d_r})) * PP_W'(d_abs_r);
    slow_pi_nxt  = PI_W'($signed({1'b0, slow_i_r})) * PI_W'(abs_error_sum_r);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      steer_pp_r <= steer_pp_nxt;
      steer_pd_r <= steer_pd_nxt;
      steer_pi_r <= steer_pi_nxt;
      slow_pp_r  <= slow_pp_nxt;
      slow_pd_r  <= slow_pd_nxt;
      slow_pi_r  <= slow_pi_nxt;
      err_b_r    <= prev_error_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum of the three products of each PID, still in Q12.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] steer_acc_r, slow_acc_r;
  logic signed [ERR_W-1:0] err_c_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      steer_acc_r <= ACC_W'(steer_pp_r) + ACC_W'(steer_pd_r) + ACC_W'(steer_pi_r);
      slow_acc_r  <= ACC_W'(slow_pp_r) + ACC_W'(slow_pd_r) + ACC_W'(slow_pi_r);
      err_c_r     <= err_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: drop the fraction toward zero, mix into wheel speeds, clamp.
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] right_r, left_r;
  logic signed [ERR_W-1:0]   perr_r;

  logic signed [Q_W-1:0]   steer_q, slow_q;
  logic signed [SPD_W-1:0] right_wide, left_wide, base_wide;

  // Divide by 2^FRAC_W rounding toward zero: bias negative values first.
  function automatic logic signed [Q_W-1:0] q12_trunc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] biased;
    biased = a + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{a[ACC_W-1]}}});
    return biased[ACC_W-1:FRAC_W];
  endfunction

  // Upper bound first, then the lower bound, which wins if they cross.
  function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [SPD_W-1:0] v);
    logic signed [SPD_W-1:0] t;
    t = v;
    if (t > SPD_W'(SPEED_UPPER)) begin
      t = SPD_W'(SPEED_UPPER);
    end
    if (t < SPD_W'(SPEED_LOWER)) begin
      t = SPD_W'(SPEED_LOWER);
    end
    return t[SPEED_W-1:0];
  endfunction

  always_comb begin
    steer_q    = q12_trunc(steer_acc_r);
    slow_q     = q12_trunc(slow_acc_r);
    base_wide  = SPD_W'(cruise_r) - SPD_W'(slow_q);
    right_wide = base_wide + SPD_W'(steer_q);
    left_wide  = base_wide - SPD_W'(steer_q);
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      right_r <= clamp_speed(right_wide);
      left_r  <= clamp_speed(left_wide);
      perr_r  <= err_c_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.right_speed    = right_r;
  assign out_chan.left_speed     = left_r;
  assign out_chan.position_error = perr_r;

endmodule

// ----- design/dpdd_checker.sv -----
// ----------------------------------------------------------------------------
// Drive controller port checker
// Watches the channels of the drive controller for handshake, reset,
// latency and speed-bound violations; bound to the top level below.
// ----------------------------------------------------------------------------
module dpdd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [dpdd_pkg::SPEED_W-1:0]    right_speed,
  input logic signed [dpdd_pkg::SPEED_W-1:0]    left_speed,
  input logic signed [dpdd_pkg::ERR_W-1:0]      position_error
);
  import dpdd_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(right_speed) && $stable(left_speed) && $stable(position_error))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline and opens the input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("pipeline not empty after reset");

  // With the receiver ready throughout, a sample that went in comes out on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing four cycles after input transfer");

  // Both wheel speeds stay inside the motor bounds.
  a_speed_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> right_speed <= SPEED_UPPER && right_speed >= SPEED_LOWER &&
                  left_speed <= SPEED_UPPER && left_speed >= SPEED_LOWER)
    else $error("wheel speed outside motor bounds");

endmodule

bind dual_pid_differential_drive dpdd_checker u_dpdd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .right_speed    (out_chan.right_speed),
  .left_speed     (out_chan.left_speed),
  .position_error (out_chan.position_error)
);
